// ===== rtl/core/sorted_table_nearest_insert_core_assert.svh =====
// Assertion macros used by the checker file of the sorted table core.
`ifndef SORTED_TABLE_NEAREST_INSERT_CORE_ASSERT_SVH
`define SORTED_TABLE_NEAREST_INSERT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define STI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define STI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sti_pkg.sv =====
package sti_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_BITS  = 16;
  localparam int ID_BITS     = 16;
  localparam int IN_VALUE_BITS = 16;
  localparam int POS_BITS    = 8;

  // Index width, kept at two bits or more so both read levels have bits.
  localparam int IDX_BITS  = ($clog2(TABLE_DEPTH) < 2) ? 2 : $clog2(TABLE_DEPTH);
  localparam int CNT_BITS  = IDX_BITS + 1;
  localparam int PAD_DEPTH = 2 ** IDX_BITS;

  // Two-level read path: HI_BITS pick a group, LO_BITS pick a cell in it.
  localparam int HI_BITS    = IDX_BITS / 2;
  localparam int LO_BITS    = IDX_BITS - HI_BITS;
  localparam int GROUPS     = 2 ** HI_BITS;
  localparam int GROUP_SIZE = 2 ** LO_BITS;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic TABLE_TEMPO = 1'b0;
  localparam logic TABLE_KEY   = 1'b1;

  localparam logic signed [1:0] ORD_LESS    = -2'sd1;
  localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORD_GREATER = 2'sd1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [ID_BITS-1:0]    id;
  } entry_t;

  // Insert command broadcast along a cell chain.
  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] pos;
    entry_t              entry;
  } ins_cmd_t;

endpackage

// ===== rtl/core/sti_cell.sv =====
module sti_cell
  import sti_pkg::*;
(
  input  logic                clk,
  input  logic [IDX_BITS-1:0] cell_idx,
  input  ins_cmd_t            ins,
  input  entry_t              left_entry,
  output entry_t              entry
);

  // The new entry lands at the insert position; every cell above it
  // takes its lower neighbor's entry in the same cycle.
  always_ff @(posedge clk) begin
    if (ins.en) begin
      if (cell_idx == ins.pos) begin
        entry <= ins.entry;
      end else if (cell_idx > ins.pos) begin
        entry <= left_entry;
      end
    end
  end

endmodule

// ===== rtl/core/sti_chain.sv =====
module sti_chain
  import sti_pkg::*;
(
  input  logic                clk,
  input  ins_cmd_t            ins,
  input  logic [IDX_BITS-1:0] rd_idx,
  output entry_t              rd_entry
);

  entry_t cell_entry [PAD_DEPTH];
  entry_t group_q    [GROUPS];

  for (genvar i = 0; i < PAD_DEPTH; i++) begin : g_cell
    if (i < TABLE_DEPTH) begin : g_real
      sti_cell u_cell (
        .clk        (clk),
        .cell_idx   (IDX_BITS'(i)),
        .ins        (ins),
        .left_entry ((i == 0) ? ins.entry : cell_entry[(i == 0) ? 0 : i - 1]),
        .entry      (cell_entry[i])
      );
    end else begin : g_pad
      assign cell_entry[i] = '0;
    end
  end

  // First read level: every group registers the cell chosen by the low bits.
  for (genvar g = 0; g < GROUPS; g++) begin : g_group
    always_ff @(posedge clk) begin
      group_q[g] <= cell_entry[{HI_BITS'(g), rd_idx[LO_BITS-1:0]}];
    end
  end

  // Second read level picks the group.
  always_ff @(posedge clk) begin
    rd_entry <= group_q[rd_idx[IDX_BITS-1:LO_BITS]];
  end

endmodule

// ===== rtl/core/sorted_table_nearest_insert_core.sv =====
// Each table read passes the RD0, RD1 and EVAL states (two registered read levels
// plus evaluate); a request on an empty table goes straight to the push step, and
// otherwise makes up to log2(TABLE_DEPTH)+2 reads (binary search plus final pair).
// Requests are taken only in the idle state, so one request is handled at a time.
// Reset: synchronous active-high rst empties both tables and drops out_valid.
module sorted_table_nearest_insert_core
  import sti_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic                      table_select,
  input  logic [IN_VALUE_BITS-1:0]  value,
  input  logic [ID_BITS-1:0]        entry_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [POS_BITS-1:0]       position,
  output logic [ID_BITS-1:0]        nearest_id,
  output logic [IN_VALUE_BITS-1:0]  nearest_value,
  output logic signed [1:0]         order,
  output logic                      table_empty,
  output logic                      table_full
);

  // The controller walks a request through read, evaluate and write steps.
  // Each table lives in its own chain of cells; the chain reads one entry
  // through a two-level registered mux, and an insert shifts the upper part
  // of the chain up by one cell, all of its cells in the same cycle.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD0   = 6'b000010,
    S_RD1   = 6'b000100,
    S_EVAL  = 6'b001000,
    S_PUSH  = 6'b010000,
    S_WRITE = 6'b100000
  } state_t;

  // What the entry coming out of the read path is used for.
  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_CUR    = 2'd1,
    PH_NEXT   = 2'd2
  } phase_t;

  state_t state;
  phase_t phase;

  // Request registers.
  logic                  is_query;
  logic                  sel;
  logic [VALUE_BITS-1:0] q;
  logic [ID_BITS-1:0]    req_id;
  logic [CNT_BITS-1:0]   cnt;

  // Search registers.
  logic [CNT_BITS-1:0]   low;
  logic [CNT_BITS-1:0]   high;
  logic [IDX_BITS-1:0]   idx;
  logic [IDX_BITS-1:0]   rd_idx;
  entry_t                cur;

  // Result held until the output register is free.
  logic [CNT_BITS-1:0]   res_pos;
  entry_t                res_entry;
  logic signed [1:0]     res_ord;
  logic                  res_empty;
  logic                  res_full;

  logic [CNT_BITS-1:0]   tempo_count;
  logic [CNT_BITS-1:0]   keyed_count;

  entry_t   tempo_rd;
  entry_t   keyed_rd;
  entry_t   rd_entry;
  ins_cmd_t tempo_ins;
  ins_cmd_t keyed_ins;
  ins_cmd_t ins_cmd;

  logic                  in_take;
  logic                  out_free;
  logic [CNT_BITS-1:0]   sel_count;

  // Search step values.
  logic                  probe_lt;
  logic [CNT_BITS-1:0]   new_low;
  logic [CNT_BITS-1:0]   new_high;
  logic [CNT_BITS:0]     mid_sum;
  logic [CNT_BITS-1:0]   new_mid;
  logic [CNT_BITS-1:0]   idx_plus;
  logic                  has_next;
  logic                  next_closer;

  // Finishing values.
  logic                  fin_en;
  logic [IDX_BITS-1:0]   fin_idx;
  entry_t                fin_entry;
  logic signed [1:0]     fin_ord;
  logic [CNT_BITS-1:0]   fin_pos;

  function automatic logic [VALUE_BITS-1:0] dist_of(
    input logic [VALUE_BITS-1:0] a,
    input logic [VALUE_BITS-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign sel_count = (table_select == TABLE_KEY) ? keyed_count : tempo_count;
  assign rd_entry  = (sel == TABLE_KEY) ? keyed_rd : tempo_rd;

  // One binary-search step from the probed entry.
  always_comb begin
    probe_lt    = (rd_entry.value < q);
    new_low     = probe_lt ? CNT_BITS'(idx) : low;
    new_high    = probe_lt ? high : CNT_BITS'(idx);
    mid_sum     = {1'b0, new_low} + {1'b0, new_high};
    new_mid     = mid_sum[CNT_BITS:1];
    idx_plus    = CNT_BITS'(idx) + CNT_BITS'(1);
    has_next    = (cnt > idx_plus);
    next_closer = (dist_of(rd_entry.value, q) < dist_of(cur.value, q));
  end

  // Decide when the evaluate step ends the search and which entry wins.
  always_comb begin
    fin_en    = 1'b0;
    fin_idx   = idx;
    fin_entry = rd_entry;
    if (state == S_EVAL) begin
      unique case (phase)
        PH_SEARCH: begin
          // An exact hit ends the search with no neighbor check.
          fin_en = (rd_entry.value == q);
        end
        PH_CUR: begin
          fin_en = !has_next;
        end
        PH_NEXT: begin
          fin_en = 1'b1;
          if (next_closer) begin
            fin_idx = IDX_BITS'(idx_plus);
          end else begin
            fin_entry = cur;
          end
        end
        default: begin
          fin_en = 1'b0;
        end
      endcase
    end
    priority if (q > fin_entry.value) begin
      fin_ord = ORD_GREATER;
    end else if (q < fin_entry.value) begin
      fin_ord = ORD_LESS;
    end else begin
      fin_ord = ORD_EQUAL;
    end
    // An insert goes just above a smaller nearest entry.
    fin_pos = CNT_BITS'(fin_idx) +
              CNT_BITS'((is_query == KIND_INSERT) && (fin_ord == ORD_GREATER));
  end

  // Insert command, issued in the write state to the selected chain only.
  assign ins_cmd.en    = (state == S_WRITE);
  assign ins_cmd.pos   = res_pos[IDX_BITS-1:0];
  assign ins_cmd.entry = '{value: q, id: req_id};

  always_comb begin
    tempo_ins    = ins_cmd;
    keyed_ins    = ins_cmd;
    tempo_ins.en = ins_cmd.en && (sel == TABLE_TEMPO);
    keyed_ins.en = ins_cmd.en && (sel == TABLE_KEY);
  end

  sti_chain u_tempo_chain (
    .clk      (clk),
    .ins      (tempo_ins),
    .rd_idx   (rd_idx),
    .rd_entry (tempo_rd)
  );

  sti_chain u_keyed_chain (
    .clk      (clk),
    .ins      (keyed_ins),
    .rd_idx   (rd_idx),
    .rd_entry (keyed_rd)
  );

  // Payload registers: request, search and result data.
  always_ff @(posedge clk) begin
    if (in_take) begin
      is_query <= kind;
      sel      <= table_select;
      q        <= VALUE_BITS'(value);
      req_id   <= entry_id;
      cnt      <= sel_count;
      low      <= '0;
      high     <= sel_count;
      idx      <= IDX_BITS'(sel_count >> 1);
      rd_idx   <= IDX_BITS'(sel_count >> 1);
      // An empty table answers at once with zeros and position 0.
      res_pos   <= '0;
      res_entry <= '0;
      res_ord   <= ORD_EQUAL;
      res_empty <= 1'b1;
      res_full  <= 1'b0;
    end
    if (state == S_EVAL) begin
      if (fin_en) begin
        idx       <= fin_idx;
        res_pos   <= fin_pos;
        res_entry <= fin_entry;
        res_ord   <= fin_ord;
        res_empty <= 1'b0;
        // A full table still reports where the entry would have gone.
        res_full  <= (is_query == KIND_INSERT) && (cnt == CNT_BITS'(TABLE_DEPTH));
      end else begin
        unique case (phase)
          PH_SEARCH: begin
            low    <= new_low;
            high   <= new_high;
            idx    <= IDX_BITS'(new_mid);
            rd_idx <= IDX_BITS'(new_mid);
          end
          PH_CUR: begin
            cur    <= rd_entry;
            rd_idx <= IDX_BITS'(idx_plus);
          end
          default: begin
            rd_idx <= rd_idx;
          end
        endcase
      end
    end
    if ((state == S_PUSH) && out_free) begin
      position      <= POS_BITS'(res_pos);
      nearest_id    <= res_entry.id;
      nearest_value <= IN_VALUE_BITS'(res_entry.value);
      order         <= res_ord;
      table_empty   <= res_empty;
      table_full    <= res_full;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_SEARCH;
      out_valid   <= 1'b0;
      tempo_count <= '0;
      keyed_count <= '0;
    end else begin
      // A new result replaces the old one only once the old one has left.
      if ((state == S_PUSH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (sel_count == '0) begin
              state <= S_PUSH;
            end else begin
              // A single entry needs no search, only the final read.
              phase <= (sel_count == CNT_BITS'(1)) ? PH_CUR : PH_SEARCH;
              state <= S_RD0;
            end
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (fin_en) begin
            state <= S_PUSH;
          end else begin
            unique case (phase)
              PH_SEARCH: begin
                // The search ends once the window is one entry wide.
                if (new_high == new_low + CNT_BITS'(1)) begin
                  phase <= PH_CUR;
                end
              end
              PH_CUR: begin
                phase <= PH_NEXT;
              end
              default: begin
                phase <= phase;
              end
            endcase
            state <= S_RD0;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            if ((is_query == KIND_INSERT) && !res_full) begin
              state <= S_WRITE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_WRITE: begin
          if (sel == TABLE_KEY) begin
            keyed_count <= keyed_count + CNT_BITS'(1);
          end else begin
            tempo_count <= tempo_count + CNT_BITS'(1);
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/sti_checker.sv =====
`include "sorted_table_nearest_insert_core_assert.svh"

module sti_checker
  import sti_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      kind,
  input logic                      table_select,
  input logic [IN_VALUE_BITS-1:0]  value,
  input logic [ID_BITS-1:0]        entry_id,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [POS_BITS-1:0]       position,
  input logic [ID_BITS-1:0]        nearest_id,
  input logic [IN_VALUE_BITS-1:0]  nearest_value,
  input logic signed [1:0]         order,
  input logic                      table_empty,
  input logic                      table_full
);

  `STI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(position) && $stable(nearest_id) && $stable(order), "stalled result changed")
  `STI_ASSERT_NOW(a_order_code, clk, rst, out_valid, order != 2'b10, "order outside -1..1")
  `STI_ASSERT_NOW(a_empty_zero, clk, rst, out_valid && table_empty, (position == '0) && (nearest_id == '0) && (nearest_value == '0) && (order == ORD_EQUAL) && !table_full, "empty table result not zero")
  `STI_ASSERT_NOW(a_full_not_empty, clk, rst, out_valid && table_full, !table_empty, "full and empty flagged together")

endmodule

bind sorted_table_nearest_insert_core sti_checker u_sti_checker (.*);
